/* rtl/ils_pkg.sv */
`default_nettype none
package ils_pkg;

    // default list depth
    localparam int DEPTH_DEF = 256;

    // fixed field widths of the stream words
    localparam int OPCODE_W = 3;
    localparam int INDEX_W  = 9;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 8;
    localparam int COUNT_W  = 9;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 56;

    // operation codes
    typedef enum logic [OPCODE_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_SET    = 3'd2,
        OP_GET    = 3'd3,
        OP_FIND   = 3'd4,
        OP_REMOVE = 3'd5
    } ils_op_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } ils_status_t;

    // work done during one lap of the ring
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_INSERT,
        ACT_REMOVE,
        ACT_SET,
        ACT_GET,
        ACT_FIND
    } ils_act_t;

    // controller state
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } ils_state_t;

    // drive of the cell ring
    typedef struct packed {
        logic               shift;
        logic [VALUE_W-1:0] din;
    } ils_ring_t;

endpackage
`default_nettype wire

/* rtl/ils_cell.sv */
`default_nettype none
module ils_cell (
    input  wire logic                        aclk,
    input  wire logic                        shift,
    input  wire logic [ils_pkg::VALUE_W-1:0] din,
    output logic      [ils_pkg::VALUE_W-1:0] dout
);
    import ils_pkg::*;

    logic [VALUE_W-1:0] data_reg;

    // one list entry, moves one cell toward the head on shift
    always_ff @(posedge aclk) begin
        if (shift) begin
            data_reg <= din;
        end
    end

    assign dout = data_reg;

endmodule
`default_nettype wire

/* rtl/ils_ctrl.sv */
`default_nettype none
module ils_ctrl #(
    parameter int DEPTH = ils_pkg::DEPTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [ils_pkg::S_DATA_W-1:0] s_tdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [ils_pkg::M_DATA_W-1:0] m_tdata,
    input  wire logic [ils_pkg::VALUE_W-1:0]  head,
    input  wire logic [ils_pkg::VALUE_W-1:0]  head_next,
    output ils_pkg::ils_ring_t                ring
);
    import ils_pkg::*;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (INDEX_W > CNT_W) ? INDEX_W : CNT_W;
    localparam int POSX_W = (IDX_W > POS_W) ? IDX_W : POS_W;
    localparam int CNTX_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    ils_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   step_reg;
    ils_act_t           act_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [VALUE_W-1:0] prev_reg;
    logic [VALUE_W-1:0] rd_reg;
    logic [IDX_W-1:0]   pos_reg;
    ils_status_t        status_reg;
    logic               m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    // accept-time decode
    logic [OPCODE_W-1:0] in_op;
    logic [INDEX_W-1:0]  in_index;
    logic [VALUE_W-1:0]  in_value;
    logic [CMP_W-1:0]    idx_ext;
    logic [CMP_W-1:0]    cnt_ext;
    logic                full;
    logic                accept;
    logic                load_out;
    ils_act_t            act_dec;
    ils_status_t         status_dec;
    logic [IDX_W-1:0]    idx_dec;
    logic [CNT_W-1:0]    count_dec;

    // lap control
    logic                at_idx;
    logic                below_idx;
    logic                last_step;
    logic                hit;
    logic [POSX_W-1:0]   pos_ext;
    logic [CNTX_W-1:0]   cnt_out_ext;

    assign in_op    = s_tdata[OPCODE_W-1:0];
    assign in_index = s_tdata[OPCODE_W +: INDEX_W];
    assign in_value = s_tdata[OPCODE_W + INDEX_W +: VALUE_W];
    assign idx_ext  = CMP_W'(in_index);
    assign cnt_ext  = CMP_W'(count_reg);
    assign full     = (count_reg == CNT_W'(DEPTH));

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    // opcode decode and bounds checks
    always_comb begin
        act_dec    = ACT_NONE;
        status_dec = ST_OK;
        idx_dec    = idx_ext[IDX_W-1:0];
        count_dec  = count_reg;
        case (in_op)
            OP_APPEND: begin
                idx_dec = cnt_ext[IDX_W-1:0];
                if (full) begin
                    status_dec = ST_FULL;
                end else begin
                    act_dec   = ACT_INSERT;
                    count_dec = count_reg + CNT_W'(1);
                end
            end
            OP_INSERT: begin
                if (idx_ext > cnt_ext) begin
                    status_dec = ST_RANGE;
                end else if (full) begin
                    status_dec = ST_FULL;
                end else begin
                    act_dec   = ACT_INSERT;
                    count_dec = count_reg + CNT_W'(1);
                end
            end
            OP_SET: begin
                if (idx_ext < cnt_ext) begin
                    act_dec = ACT_SET;
                end else begin
                    status_dec = ST_RANGE;
                end
            end
            OP_GET: begin
                if (idx_ext < cnt_ext) begin
                    act_dec = ACT_GET;
                end else begin
                    status_dec = ST_RANGE;
                end
            end
            OP_FIND: begin
                act_dec    = ACT_FIND;
                status_dec = ST_NOTFOUND;
            end
            OP_REMOVE: begin
                if (idx_ext < cnt_ext) begin
                    act_dec   = ACT_REMOVE;
                    count_dec = count_reg - CNT_W'(1);
                end else begin
                    status_dec = ST_RANGE;
                end
            end
            default: begin
                act_dec = ACT_NONE;
            end
        endcase
    end

    assign at_idx    = (step_reg == idx_reg);
    assign below_idx = (step_reg < idx_reg);
    assign last_step = (step_reg == IDX_W'(DEPTH - 1));
    assign hit       = (act_reg == ACT_FIND) && (status_reg == ST_NOTFOUND) &&
                       (CNT_W'(step_reg) < count_reg) && (head == val_reg);

    // word fed back into the tail of the ring
    always_comb begin
        ring.shift = (state_reg == ST_RUN);
        case (act_reg)
            ACT_INSERT: begin
                if (below_idx) begin
                    ring.din = head;
                end else if (at_idx) begin
                    ring.din = val_reg;
                end else begin
                    ring.din = prev_reg;
                end
            end
            ACT_REMOVE: begin
                ring.din = below_idx ? head : head_next;
            end
            ACT_SET: begin
                ring.din = at_idx ? val_reg : head;
            end
            default: begin
                ring.din = head;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (last_step) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                count_reg <= count_dec;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // per-word working registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg    <= act_dec;
            status_reg <= status_dec;
            idx_reg    <= idx_dec;
            val_reg    <= in_value;
            rd_reg     <= '0;
            pos_reg    <= '0;
            step_reg   <= '0;
        end else if (state_reg == ST_RUN) begin
            step_reg <= step_reg + IDX_W'(1);
            prev_reg <= head;
            if (at_idx && (act_reg == ACT_GET || act_reg == ACT_REMOVE)) begin
                rd_reg <= head;
            end
            if (hit) begin
                status_reg <= ST_OK;
                pos_reg    <= step_reg;
            end
        end
    end

    assign pos_ext     = POSX_W'(pos_reg);
    assign cnt_out_ext = CNTX_W'(count_reg);

    // result register
    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= {5'd0, cnt_out_ext[COUNT_W-1:0], pos_ext[POS_W-1:0],
                           rd_reg, status_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

/* rtl/indexed_list_store_unit.sv */
`default_nettype none
// Channel | Dir | Bits of tdata, lowest first
// s_      | in  | opcode[2:0] index[11:3] value[43:12] zero[47:44]
// m_      | out | status[1:0] read_value[33:2] position[41:34] count[50:42] zero[55:51]
//
// Every word makes one full lap of the DEPTH-cell ring, whatever the opcode,
// before its result word is loaded into the result register.
// One word is worked on at a time; s_tready is high only while idle. The
// result register lets the next word be taken while a result waits.
// A stalled m_ side holds the finished word in the controller until taken.
// aresetn clears the count and control; cell contents are left as they are.
module indexed_list_store_unit #(
    parameter int DEPTH = ils_pkg::DEPTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [ils_pkg::S_DATA_W-1:0] s_tdata,  // opcode, index, value
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [ils_pkg::M_DATA_W-1:0] m_tdata   // status, read_value, position, count
);
    import ils_pkg::*;

    ils_ring_t          ring;
    logic [VALUE_W-1:0] cell_q [DEPTH];

    // sequencer and result register
    ils_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .head     (cell_q[0]),
        .head_next(cell_q[1]),
        .ring     (ring)
    );

    // ring of entry cells, tail fed by the controller
    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        if (j == DEPTH - 1) begin : g_tail
            ils_cell u_cell (
                .aclk (aclk),
                .shift(ring.shift),
                .din  (ring.din),
                .dout (cell_q[j])
            );
        end else begin : g_body
            ils_cell u_cell (
                .aclk (aclk),
                .shift(ring.shift),
                .din  (cell_q[j+1]),
                .dout (cell_q[j])
            );
        end
    end

endmodule
`default_nettype wire

/* verif/tb_top.sv */
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ils_pkg::*;

    localparam int LIST_DEPTH  = DEPTH_DEF;
    localparam int RESULT_W    = STATUS_W + VALUE_W + POS_W + COUNT_W;
    localparam int STALL_LIMIT = 4000;
    localparam int FULL_DWELL  = 12;
    localparam int EMPTY_DWELL = 4;

    // opcodes outside the defined set; the block must leave the list alone
    localparam logic [OPCODE_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_7 = 3'd7;

    // one command word, opcode in the low bits
    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [INDEX_W-1:0]  index;
        logic [OPCODE_W-1:0] opcode;
    } list_cmd_t;

    // one reply word, status in the low bits
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] read_value;
        ils_status_t        status;
    } list_reply_t;

    // shadow copy of the list plus the replies still owed by the block
    class list_shadow;
        logic [VALUE_W-1:0] entries [LIST_DEPTH];
        int                 length;
        int                 peak_length;
        list_reply_t        awaited_replies [$];
        int                 mismatches;
        int                 replies_checked;
        int                 status_tally [4];

        function new();
            length          = 0;
            peak_length     = 0;
            mismatches      = 0;
            replies_checked = 0;
            foreach (status_tally[i]) status_tally[i] = 0;
            foreach (entries[i]) entries[i] = '0;
        endfunction

        // open a slot at 'at' by moving later entries up
        function void shift_in(int at, logic [VALUE_W-1:0] v);
            for (int i = length; i > at; i--) entries[i] = entries[i-1];
            entries[at] = v;
            length++;
        endfunction

        // run one command on the shadow list and build its reply
        function list_reply_t apply_command(list_cmd_t c);
            list_reply_t r;
            int          idx;
            r        = '0;
            r.status = ST_OK;
            idx      = int'(c.index);
            case (c.opcode)
                OP_APPEND: begin
                    if (length >= LIST_DEPTH) r.status = ST_FULL;
                    else shift_in(length, c.value);
                end
                OP_INSERT: begin
                    // range check wins over the full check
                    if (idx > length) r.status = ST_RANGE;
                    else if (length >= LIST_DEPTH) r.status = ST_FULL;
                    else shift_in(idx, c.value);
                end
                OP_SET: begin
                    if (idx < length) entries[idx] = c.value;
                    else r.status = ST_RANGE;
                end
                OP_GET: begin
                    if (idx < length) r.read_value = entries[idx];
                    else r.status = ST_RANGE;
                end
                OP_FIND: begin
                    r.status = ST_NOTFOUND;
                    for (int i = 0; i < length; i++) begin
                        if (entries[i] == c.value) begin
                            r.status   = ST_OK;
                            r.position = POS_W'(i);
                            break;
                        end
                    end
                end
                OP_REMOVE: begin
                    if (idx < length) begin
                        r.read_value = entries[idx];
                        for (int i = idx; i + 1 < length; i++) entries[i] = entries[i+1];
                        length--;
                    end else begin
                        r.status = ST_RANGE;
                    end
                end
                default: begin
                end
            endcase
            r.count = COUNT_W'(length);
            return r;
        endfunction

        function void note_command(list_cmd_t c);
            awaited_replies.push_back(apply_command(c));
            if (length > peak_length) peak_length = length;
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data);
            list_reply_t got;
            list_reply_t want;
            logic        bad;
            got = list_reply_t'(data[RESULT_W-1:0]);
            if (awaited_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: reply word with nothing outstanding: %h", $time, data);
                return;
            end
            want = awaited_replies.pop_front();
            replies_checked++;
            status_tally[int'(want.status)]++;
            bad = (got.status !== want.status) || (got.read_value !== want.read_value) ||
                  (got.position !== want.position) || (got.count !== want.count) ||
                  ((data >> RESULT_W) !== '0);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: reply %0d exp st=%0d rd=%h pos=%0d cnt=%0d got st=%0d rd=%h pos=%0d cnt=%0d pad=%h",
                             $time, replies_checked, want.status, want.read_value, want.position,
                             want.count, got.status, got.read_value, got.position, got.count,
                             data >> RESULT_W);
            end
        endfunction
    endclass

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    list_shadow tracker;
    int         send_idle_pct  = 0;
    int         recv_idle_pct  = 0;
    int         quiet_cycles   = 0;
    int         commands_sent  = 0;
    int         directed_count = 0;
    bit         growing        = 1'b1;
    int         full_hits      = 0;
    int         empty_hits     = 0;

    indexed_list_store_unit #(.DEPTH(LIST_DEPTH)) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // reply side: check accepted words, random back-pressure, idle watch
    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else begin
            if (m_tvalid && m_tready) tracker.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // hang watchdog
    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge aclk);
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("indexed_list_store_unit verification failed");
        $finish;
    end

    function automatic list_cmd_t make_cmd(logic [OPCODE_W-1:0] op, int idx,
                                           logic [VALUE_W-1:0] val);
        list_cmd_t c;
        c.opcode = op;
        c.index  = INDEX_W'(idx);
        c.value  = val;
        return c;
    endfunction

    // mix of wide random, small clustered, extremes and values already stored
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom();
            1: return VALUE_W'($urandom_range(31)) - 32'd16;
            2: begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: begin
                if (tracker.length == 0) return $urandom();
                return tracker.entries[$urandom_range(tracker.length - 1)];
            end
        endcase
    endfunction

    // mostly near the live range, sometimes anywhere in the field
    function automatic logic [INDEX_W-1:0] pick_index();
        if ($urandom_range(9) < 8) return INDEX_W'($urandom_range(tracker.length));
        return INDEX_W'($urandom_range(511));
    endfunction

    function automatic logic [OPCODE_W-1:0] pick_opcode(bit grow);
        int roll;
        roll = $urandom_range(99);
        if (roll < 2) return $urandom_range(1) ? OP_UNUSED_6 : OP_UNUSED_7;
        if (grow) begin
            if (roll < 37) return OP_APPEND;
            if (roll < 62) return OP_INSERT;
            if (roll < 72) return OP_SET;
            if (roll < 82) return OP_GET;
            if (roll < 92) return OP_FIND;
            return OP_REMOVE;
        end
        if (roll < 52) return OP_REMOVE;
        if (roll < 59) return OP_APPEND;
        if (roll < 66) return OP_INSERT;
        if (roll < 76) return OP_SET;
        if (roll < 86) return OP_GET;
        return OP_FIND;
    endfunction

    // present one command word, with random gaps ahead of it
    task automatic send_cmd(list_cmd_t c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(c);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.note_command(c);
        commands_sent++;
    endtask

    // hold off the command side until every reply has come back
    task automatic wait_all_replies();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tracker.awaited_replies.size() != 0);
    endtask

    task automatic run_directed();
        // empty list: every indexed access is out of range, search misses
        send_cmd(make_cmd(OP_GET, 0, 32'h0));
        send_cmd(make_cmd(OP_REMOVE, 0, 32'h0));
        send_cmd(make_cmd(OP_FIND, 0, 32'h0));
        send_cmd(make_cmd(OP_SET, 0, 32'h1234_5678));
        send_cmd(make_cmd(OP_INSERT, 1, 32'h1));
        // build a short list through each add path
        send_cmd(make_cmd(OP_INSERT, 0, 32'h8000_0000));
        send_cmd(make_cmd(OP_APPEND, 0, 32'h7FFF_FFFF));
        send_cmd(make_cmd(OP_APPEND, 0, 32'hFFFF_FFFF));
        send_cmd(make_cmd(OP_INSERT, tracker.length, 32'h0));
        send_cmd(make_cmd(OP_INSERT, 1, 32'd5));
        send_cmd(make_cmd(OP_APPEND, 0, 32'd5));
        // duplicate value: first position must come back
        send_cmd(make_cmd(OP_FIND, 0, 32'd5));
        send_cmd(make_cmd(OP_FIND, 0, 32'd12345));
        // top index bit set
        send_cmd(make_cmd(OP_GET, 256, 32'h0));
        send_cmd(make_cmd(OP_SET, 511, 32'hFFFF_FFFF));
        send_cmd(make_cmd(OP_INSERT, 256, 32'h1));
        send_cmd(make_cmd(OP_SET, 2, 32'h5555_5555));
        send_cmd(make_cmd(OP_GET, 2, 32'hAAAA_AAAA));
        // remove at both ends
        send_cmd(make_cmd(OP_REMOVE, 0, 32'h0));
        send_cmd(make_cmd(OP_REMOVE, tracker.length - 1, 32'h0));
        // undefined opcodes, one with every bit of the other fields set, one with them clear
        send_cmd(make_cmd(OP_UNUSED_6, 511, 32'hFFFF_FFFF));
        send_cmd(make_cmd(OP_UNUSED_7, 0, 32'h0));
        send_cmd(make_cmd(OP_GET, 0, 32'h0));
        send_cmd(make_cmd(OP_FIND, 0, 32'h8000_0000));
        directed_count = commands_sent;
    endtask

    // alternate between filling to full and draining to empty
    task automatic run_random(int items);
        list_cmd_t c;
        for (int n = 0; n < items; n++) begin
            if (tracker.length == LIST_DEPTH) full_hits++;
            if (tracker.length == 0) empty_hits++;
            if (growing && full_hits >= FULL_DWELL) begin
                growing   = 1'b0;
                full_hits = 0;
            end else if (!growing && empty_hits >= EMPTY_DWELL) begin
                growing    = 1'b1;
                empty_hits = 0;
            end
            c.opcode = pick_opcode(growing);
            c.index  = pick_index();
            c.value  = pick_value();
            if ($urandom_range(39) == 0) wait_all_replies();
            send_cmd(c);
        end
    endtask

    initial begin
        tracker = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 23;
        recv_idle_pct = 45;
        run_directed();
        run_random(530);
        wait_all_replies();

        send_idle_pct = 45;
        recv_idle_pct = 23;
        run_random(530);
        wait_all_replies();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(530);
        wait_all_replies();

        // let a stray late word show up before closing
        repeat (LIST_DEPTH + 8) @(posedge aclk);

        $display("sent %0d commands (%0d directed), checked %0d replies, list peaked at %0d of %0d",
                 commands_sent, directed_count, tracker.replies_checked, tracker.peak_length,
                 LIST_DEPTH);
        $display("replies by status: ok %0d, out of range %0d, full %0d, not found %0d; bad %0d",
                 tracker.status_tally[0], tracker.status_tally[1], tracker.status_tally[2],
                 tracker.status_tally[3], tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.awaited_replies.size() == 0) begin
            $display("indexed_list_store_unit verification clean");
        end else begin
            $display("indexed_list_store_unit verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
